[hdl/rbuv_pkg.sv]
`default_nettype none
package rbuv_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IW = 16;
	localparam int ONE = 1 << FRAC_BITS;
	localparam int HALF = 1 << (FRAC_BITS - 1);
	localparam int OUT_MAX = (ONE > 32767) ? 32767 : ONE;
	localparam int OUT_MIN = (ONE > 32768) ? -32768 : -ONE;

	// products, cross/dot sums, rounded v/c, v products
	localparam int PW = 2 * IW;
	localparam int XW = PW + 2;
	localparam int VW = XW - FRAC_BITS;
	localparam int DW = VW;
	localparam int SQW = 2 * VW;
	localparam int MW = SQW + 1;
	localparam int RW = MW + 2;
	// quotients at or above 2^QB saturate every entry anyway
	localparam int QB = VW + 1;
	localparam int EW = QB + 3;

	localparam int FRONT_LAT = 5;
	localparam int DIV_LAT = QB + 1;
	localparam int LATENCY = FRONT_LAT + DIV_LAT + 1;

	typedef struct packed {
		logic signed [IW-1:0] ax;
		logic signed [IW-1:0] ay;
		logic signed [IW-1:0] az;
		logic signed [IW-1:0] bx;
		logic signed [IW-1:0] by;
		logic signed [IW-1:0] bz;
	} in_t;

	typedef struct packed {
		logic signed [IW-1:0] r00;
		logic signed [IW-1:0] r01;
		logic signed [IW-1:0] r02;
		logic signed [IW-1:0] r10;
		logic signed [IW-1:0] r11;
		logic signed [IW-1:0] r12;
		logic signed [IW-1:0] r20;
		logic signed [IW-1:0] r21;
		logic signed [IW-1:0] r22;
		logic opposite_flag;
	} out_t;

	// per-item data that bypasses the dividers
	typedef struct packed {
		logic signed [VW-1:0] v0;
		logic signed [VW-1:0] v1;
		logic signed [VW-1:0] v2;
		logic flag;
	} side_t;

	function automatic logic signed [IW-1:0] sat_entry(input logic signed [EW-1:0] e);
		logic signed [EW-1:0] hi;
		logic signed [EW-1:0] lo;
		logic signed [EW-1:0] r;
		hi = EW'(OUT_MAX);
		lo = EW'(OUT_MIN);
		r = e;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r[IW-1:0];
	endfunction

endpackage
`default_nettype wire

[hdl/rotation_between_unit_vectors_core.sv]
// channel   | ports                     | handshake
// ----------+---------------------------+--------------------------------
// operands  | start, busy, operands     | taken when start && !busy
// config    | cfg_we, cfg_wdata         | min_denominator written on cfg_we
// result    | done, result              | one-cycle strobe, no backpressure
//
// Fully pipelined: one transaction per cycle.
// Most of the pipeline is the 22-stage restoring divider that forms K*K/(1+c).
// busy is always low; the receiver cannot stall, so the pipeline never holds.
// Reset clears the valid chain and sets min_denominator to 16.
`default_nettype none
module rotation_between_unit_vectors_core import rbuv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_t         operands,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output logic             done,
	output out_t             result
);

	logic [15:0]         min_den_q;
	side_t               side;
	logic [DW-1:0]       den;
	logic [8:0][RW-1:0]  numer;
	logic [8:0]          neg;
	logic [QB-1:0]       quot [9];
	logic [8:0]          qneg;
	side_t               side_dly_s [DIV_LAT+1];
	logic [LATENCY-1:0]  vld_q;
	out_t                result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_den_q <= 16'd16;
		end else if (cfg_we) begin
			min_den_q <= cfg_wdata;
		end
	end

	rbuv_front u_front (
		.clk      (clk),
		.operands (operands),
		.min_den  (min_den_q),
		.side     (side),
		.den      (den),
		.numer    (numer),
		.neg      (neg)
	);

	for (genvar i = 0; i < 9; i++) begin : g_div
		rbuv_div u_div (
			.clk     (clk),
			.numer   (numer[i]),
			.den     (den),
			.neg_in  (neg[i]),
			.quot    (quot[i]),
			.neg_out (qneg[i])
		);
	end

	assign side_dly_s[0] = side;
	for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_dly_s[k+1] <= side_dly_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start & ~busy};
		end
	end

	side_t sd;
	logic signed [EW-1:0] kt [9];
	logic signed [EW-1:0] e  [9];
	logic signed [IW-1:0] r  [9];
	always_comb begin
		sd = side_dly_s[DIV_LAT];
		kt[0] = '0;
		kt[1] = -EW'(sd.v2);
		kt[2] = EW'(sd.v1);
		kt[3] = EW'(sd.v2);
		kt[4] = '0;
		kt[5] = -EW'(sd.v0);
		kt[6] = -EW'(sd.v1);
		kt[7] = EW'(sd.v0);
		kt[8] = '0;
		for (int i = 0; i < 9; i++) begin
			e[i] = kt[i] + (qneg[i] ? -EW'(quot[i]) : EW'(quot[i]));
			if (i == 0 || i == 4 || i == 8) begin
				e[i] = e[i] + EW'(ONE);
			end
			if (sd.flag) begin
				e[i] = (i == 0 || i == 4 || i == 8) ? EW'(ONE) : '0;
			end
			r[i] = sat_entry(e[i]);
		end
	end

	always_ff @(posedge clk) begin
		result_q.r00 <= r[0];
		result_q.r01 <= r[1];
		result_q.r02 <= r[2];
		result_q.r10 <= r[3];
		result_q.r11 <= r[4];
		result_q.r12 <= r[5];
		result_q.r20 <= r[6];
		result_q.r21 <= r[7];
		result_q.r22 <= r[8];
		result_q.opposite_flag <= sd.flag;
	end

	assign busy = 1'b0;
	assign done = vld_q[LATENCY-1];
	assign result = result_q;

endmodule
`default_nettype wire

[hdl/rbuv_front.sv]
`default_nettype none
module rbuv_front import rbuv_pkg::*; (
	input  wire logic           clk,
	input  wire in_t            operands,
	input  wire logic [15:0]    min_den,
	output side_t               side,
	output logic [DW-1:0]       den,
	output logic [8:0][RW-1:0]  numer,
	output logic [8:0]          neg
);

	logic signed [PW-1:0]  p_s1 [9];
	logic signed [VW-1:0]  v_s2 [3];
	logic signed [VW-1:0]  c_s2;
	logic signed [VW-1:0]  v_s3 [3];
	logic signed [SQW-1:0] pp_s3 [6];
	logic [DW-1:0]         d_s3;
	logic                  flag_s3;
	logic signed [VW-1:0]  v_s4 [3];
	logic [MW-1:0]         mag_s4 [9];
	logic [8:0]            neg_s4;
	logic [DW-1:0]         d_s4;
	logic                  flag_s4;
	logic signed [VW-1:0]  v_s5 [3];
	logic [RW-1:0]         n_s5 [9];
	logic [8:0]            neg_s5;
	logic [DW-1:0]         d_s5;
	logic                  flag_s5;

	logic signed [IW-1:0] a [3];
	logic signed [IW-1:0] b [3];
	assign a[0] = operands.ax;
	assign a[1] = operands.ay;
	assign a[2] = operands.az;
	assign b[0] = operands.bx;
	assign b[1] = operands.by;
	assign b[2] = operands.bz;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p_s1[i*3+j] <= PW'(a[i] * b[j]);
			end
		end
	end

	// cross and dot, rounded half up
	logic signed [XW-1:0] x [4];
	always_comb begin
		x[0] = XW'(p_s1[5]) - XW'(p_s1[7]) + XW'(HALF);
		x[1] = XW'(p_s1[6]) - XW'(p_s1[2]) + XW'(HALF);
		x[2] = XW'(p_s1[1]) - XW'(p_s1[3]) + XW'(HALF);
		x[3] = XW'(p_s1[0]) + XW'(p_s1[4]) + XW'(p_s1[8]) + XW'(HALF);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			v_s2[i] <= VW'(x[i] >>> FRAC_BITS);
		end
		c_s2 <= VW'(x[3] >>> FRAC_BITS);
	end

	logic signed [VW:0] den_full;
	logic signed [VW:0] floor_v;
	assign den_full = (VW+1)'(ONE) + (VW+1)'(c_s2);
	assign floor_v = signed'((VW+1)'(min_den));

	always_ff @(posedge clk) begin
		v_s3 <= v_s2;
		d_s3 <= den_full[DW-1:0];
		flag_s3 <= (den_full <= 0) || (den_full < floor_v);
		pp_s3[0] <= SQW'(v_s2[0] * v_s2[0]);
		pp_s3[1] <= SQW'(v_s2[1] * v_s2[1]);
		pp_s3[2] <= SQW'(v_s2[2] * v_s2[2]);
		pp_s3[3] <= SQW'(v_s2[0] * v_s2[1]);
		pp_s3[4] <= SQW'(v_s2[0] * v_s2[2]);
		pp_s3[5] <= SQW'(v_s2[1] * v_s2[2]);
	end

	// K*K: diagonal is minus the sum of the other two squares
	logic [MW-1:0] m01, m02, m12;
	always_comb begin
		m01 = pp_s3[3][SQW-1] ? MW'(unsigned'(-pp_s3[3])) : MW'(unsigned'(pp_s3[3]));
		m02 = pp_s3[4][SQW-1] ? MW'(unsigned'(-pp_s3[4])) : MW'(unsigned'(pp_s3[4]));
		m12 = pp_s3[5][SQW-1] ? MW'(unsigned'(-pp_s3[5])) : MW'(unsigned'(pp_s3[5]));
	end

	always_ff @(posedge clk) begin
		v_s4 <= v_s3;
		d_s4 <= d_s3;
		flag_s4 <= flag_s3;
		mag_s4[0] <= MW'(unsigned'(pp_s3[1])) + MW'(unsigned'(pp_s3[2]));
		mag_s4[4] <= MW'(unsigned'(pp_s3[0])) + MW'(unsigned'(pp_s3[2]));
		mag_s4[8] <= MW'(unsigned'(pp_s3[0])) + MW'(unsigned'(pp_s3[1]));
		mag_s4[1] <= m01;
		mag_s4[3] <= m01;
		mag_s4[2] <= m02;
		mag_s4[6] <= m02;
		mag_s4[5] <= m12;
		mag_s4[7] <= m12;
		neg_s4 <= {1'b1, pp_s3[5][SQW-1], pp_s3[4][SQW-1], pp_s3[5][SQW-1], 1'b1,
			pp_s3[3][SQW-1], pp_s3[4][SQW-1], pp_s3[3][SQW-1], 1'b1};
	end

	always_ff @(posedge clk) begin
		v_s5 <= v_s4;
		d_s5 <= d_s4;
		flag_s5 <= flag_s4;
		neg_s5 <= neg_s4;
		for (int i = 0; i < 9; i++) begin
			n_s5[i] <= RW'(mag_s4[i]) + RW'(d_s4 >> 1);
		end
	end

	always_comb begin
		side.v0 = v_s5[0];
		side.v1 = v_s5[1];
		side.v2 = v_s5[2];
		side.flag = flag_s5;
		den = d_s5;
		neg = neg_s5;
		for (int i = 0; i < 9; i++) begin
			numer[i] = n_s5[i];
		end
	end

endmodule
`default_nettype wire

[hdl/rbuv_div.sv]
`default_nettype none
module rbuv_div import rbuv_pkg::*; (
	input  wire logic          clk,
	input  wire logic [RW-1:0] numer,
	input  wire logic [DW-1:0] den,
	input  wire logic          neg_in,
	output logic [QB-1:0]      quot,
	output logic               neg_out
);

	// restoring divider, one quotient bit per stage; first stage only detects overflow
	logic [RW-1:0] rem_s [QB+2];
	logic [DW-1:0] d_s   [QB+2];
	logic [QB-1:0] q_s   [QB+2];
	logic          sat_s [QB+2];
	logic          neg_s [QB+2];

	always_comb begin
		rem_s[0] = numer;
		d_s[0] = den;
		q_s[0] = '0;
		sat_s[0] = 1'b0;
		neg_s[0] = neg_in;
	end

	for (genvar k = 0; k <= QB; k++) begin : g_stage
		localparam int SH = QB - k;
		logic [RW-1:0] trial;
		logic          ge;
		assign trial = RW'(d_s[k]) << SH;
		assign ge = rem_s[k] >= trial;

		always_ff @(posedge clk) begin
			d_s[k+1] <= d_s[k];
			neg_s[k+1] <= neg_s[k];
			if (k == 0) begin
				rem_s[k+1] <= rem_s[k];
				q_s[k+1] <= '0;
				sat_s[k+1] <= ge;
			end else begin
				rem_s[k+1] <= ge ? rem_s[k] - trial : rem_s[k];
				q_s[k+1] <= q_s[k] | (ge ? QB'(1) << SH : '0);
				sat_s[k+1] <= sat_s[k];
			end
		end
	end

	assign quot = sat_s[QB+1] ? '1 : q_s[QB+1];
	assign neg_out = neg_s[QB+1];

endmodule
`default_nettype wire

[hdl/rbuv_checker.sv]
`default_nettype none
module rbuv_props import rbuv_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire out_t result
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("transaction did not complete at fixed latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching transaction");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.opposite_flag) |->
		(result.r01 == 0 && result.r02 == 0 && result.r10 == 0 && result.r12 == 0 &&
		result.r20 == 0 && result.r21 == 0 && result.r00 == IW'(OUT_MAX)))
		else $error("flagged result is not identity");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.r00 <= IW'(OUT_MAX) && result.r00 >= IW'(OUT_MIN) &&
		result.r11 <= IW'(OUT_MAX) && result.r11 >= IW'(OUT_MIN)))
		else $error("diagonal entry outside saturation range");

endmodule

bind rotation_between_unit_vectors_core rbuv_props u_rbuv_props (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire
